[rtl/mbsm_pkg.sv]
// Package for the multi-buffer swap manager: beat structs, request and
// status codes, controller state and controller/datapath command types.
// No dependencies.
package mbsm_pkg;

  // Largest number of buffers in rotation
  localparam int MaxBuffers = 4;

  localparam int ReqW = 3;
  localparam int IdW  = 2;
  localparam int StW  = 2;
  localparam int CfgW = 3;

  // Request codes carried in req_type
  typedef enum logic [ReqW-1:0] {
    REQ_CLI_ACQ  = 3'd0,
    REQ_CLI_REL  = 3'd1,
    REQ_COMP_ACQ = 3'd2,
    REQ_COMP_REL = 3'd3,
    REQ_SHUTDOWN = 3'd4
  } req_e;

  // Result status codes
  typedef enum logic [StW-1:0] {
    ST_OK   = 2'd0,
    ST_WAIT = 2'd1,
    ST_ERR  = 2'd2
  } status_e;

  // Input beat
  typedef struct packed {
    logic [ReqW-1:0] req_type;
    logic [IdW-1:0]  release_id;
  } in_t;

  // Output beat
  typedef struct packed {
    logic [StW-1:0] status;
    logic [IdW-1:0] granted_id;
  } out_t;

  // Controller states
  typedef enum logic {
    CS_IDLE,
    CS_EXEC
  } ctrl_state_e;

  // Controller -> datapath
  typedef struct packed {
    logic capture;  // take the input beat, launch slot RAM reads
    logic exec;     // apply the request and load the output register
  } ctl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic out_blocked;  // output register full and not being drained
  } dp_sts_t;

endpackage

[rtl/multi_buffer_swap_manager_top.sv]
// Multi-buffer swap manager: hands buffer ids 0..count-1 between a
// producer (client) and a compositor through a free deque, a ready FIFO
// and a held count. A request is captured, with a read of the two slot
// RAMs (registered read), and then executed, which updates the queues
// and loads the output register. The next request is accepted as soon as the
// previous one has been executed, even while its result beat is still
// waiting. Execution holds while the output register is full and not
// being taken. Reset and count writes take effect at once: per-entry valid
// bits on the free RAM stand in for its initial contents, so there is no
// clearing pass. Write the count only while no request is in flight.
// Depends on mbsm_pkg, mbsm_ctrl, mbsm_dp, mbsm_ram.
module multi_buffer_swap_manager_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mbsm_pkg::CfgW-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  mbsm_pkg::in_t             in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output mbsm_pkg::out_t            out_data_o
);
  import mbsm_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // Sequencer
  mbsm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Queues, slot RAMs and result register
  mbsm_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

[rtl/mbsm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mbsm_ram #(
  parameter int Width = 2,
  parameter int Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/mbsm_ctrl.sv]
// Controller FSM for the multi-buffer swap manager: sequences capture and
// execute of one request at a time. Depends on mbsm_pkg.
module mbsm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mbsm_pkg::dp_sts_t sts_i,
  output mbsm_pkg::ctl_cmd_t cmd_o
);
  import mbsm_pkg::*;

  ctrl_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE: begin
        if (in_valid_i) state_d = CS_EXEC;
      end
      CS_EXEC: begin
        if (!sts_i.out_blocked) state_d = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.exec    = 1'b0;
    unique case (state_q)
      CS_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      CS_EXEC: begin
        cmd_o.exec = !sts_i.out_blocked;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/mbsm_dp.sv]
// Datapath for the multi-buffer swap manager: free deque and ready FIFO
// pointers, slot RAMs, request decode and the output register.
// Depends on mbsm_pkg and mbsm_ram.
module mbsm_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mbsm_pkg::CfgW-1:0]   cfg_data_i,
  input  mbsm_pkg::in_t               in_data_i,
  input  mbsm_pkg::ctl_cmd_t          cmd_i,
  output mbsm_pkg::dp_sts_t           sts_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output mbsm_pkg::out_t              out_data_o
);
  import mbsm_pkg::*;

  localparam int PW     = $clog2(MaxBuffers);
  localparam int CW     = $clog2(MaxBuffers + 1);
  localparam int SW     = CW + 1;
  localparam int CntRst = (MaxBuffers < 3) ? MaxBuffers : 3;

  // Circular position add with one wrap correction (sum < 2*MaxBuffers)
  function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] base, logic [CW-1:0] ofs);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(ofs);
    if (sum >= SW'(MaxBuffers)) sum = sum - SW'(MaxBuffers);
    return sum[PW-1:0];
  endfunction

  logic [CW-1:0]         buf_cnt_q;
  logic [PW-1:0]         free_head_q, free_head_d;
  logic [CW-1:0]         free_cnt_q, free_cnt_d;
  logic [PW-1:0]         ready_head_q, ready_head_d;
  logic [CW-1:0]         ready_cnt_q, ready_cnt_d;
  logic [CW-1:0]         held_q, held_d;
  logic [MaxBuffers-1:0] free_vld_q;

  logic [ReqW-1:0] req_q;
  logic [IdW-1:0]  id_q;
  logic            free_rvld_q;
  logic [PW-1:0]   free_raddr_q;

  logic [PW-1:0]   free_raddr, free_waddr, ready_waddr;
  logic [IdW-1:0]  free_wdata, ready_wdata;
  logic            free_we, ready_we;
  logic [IdW-1:0]  free_rdata, ready_rdata, free_front;
  logic [CW-1:0]   cfg_cnt;
  logic            id_ok;
  out_t            result;
  logic            out_valid_q;
  out_t            out_q;

  // Saturate a written count to the supported range
  always_comb begin
    if (cfg_data_i < CfgW'(2)) begin
      cfg_cnt = CW'(2);
    end else if (32'(cfg_data_i) > 32'(MaxBuffers)) begin
      cfg_cnt = CW'(MaxBuffers);
    end else begin
      cfg_cnt = CW'(cfg_data_i);
    end
  end

  // Free-RAM read address at capture: front for client, back for compositor
  always_comb begin
    if (in_data_i.req_type == REQ_COMP_ACQ && free_cnt_q != '0) begin
      free_raddr = wrap_add(free_head_q, CW'(free_cnt_q - CW'(1)));
    end else begin
      free_raddr = free_head_q;
    end
  end

  mbsm_ram #(.Width(IdW), .Depth(MaxBuffers)) u_free_ram (
    .clk_i  (clk_i),
    .we_i   (free_we),
    .waddr_i(free_waddr),
    .wdata_i(free_wdata),
    .re_i   (cmd_i.capture),
    .raddr_i(free_raddr),
    .rdata_o(free_rdata)
  );

  mbsm_ram #(.Width(IdW), .Depth(MaxBuffers)) u_ready_ram (
    .clk_i  (clk_i),
    .we_i   (ready_we),
    .waddr_i(ready_waddr),
    .wdata_i(ready_wdata),
    .re_i   (cmd_i.capture),
    .raddr_i(ready_head_q),
    .rdata_o(ready_rdata)
  );

  // Unwritten free entries still hold their initial id (their own slot)
  assign free_front = free_rvld_q ? free_rdata : IdW'(free_raddr_q);
  assign id_ok      = CW'(id_q) < buf_cnt_q;

  // Request capture (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q        <= in_data_i.req_type;
      id_q         <= in_data_i.release_id;
      free_rvld_q  <= free_vld_q[free_raddr];
      free_raddr_q <= free_raddr;
    end
  end

  // Request execution
  always_comb begin
    free_head_d       = free_head_q;
    free_cnt_d        = free_cnt_q;
    ready_head_d      = ready_head_q;
    ready_cnt_d       = ready_cnt_q;
    held_d            = held_q;
    free_we           = 1'b0;
    free_waddr        = wrap_add(free_head_q, free_cnt_q);
    free_wdata        = id_q;
    ready_we          = 1'b0;
    ready_waddr       = wrap_add(ready_head_q, ready_cnt_q);
    ready_wdata       = id_q;
    result.status     = ST_OK;
    result.granted_id = '0;
    unique case (req_q)
      REQ_CLI_ACQ: begin
        if (free_cnt_q == '0 || held_q >= CW'(buf_cnt_q - CW'(1))) begin
          result.status = ST_WAIT;
        end else begin
          result.granted_id = free_front;
          free_head_d       = wrap_add(free_head_q, CW'(1));
          free_cnt_d        = CW'(free_cnt_q - CW'(1));
          held_d            = CW'(held_q + CW'(1));
        end
      end
      REQ_CLI_REL: begin
        if (!id_ok || held_q == '0 || ready_cnt_q >= buf_cnt_q) begin
          result.status = ST_ERR;
        end else begin
          ready_we    = 1'b1;
          ready_cnt_d = CW'(ready_cnt_q + CW'(1));
          held_d      = CW'(held_q - CW'(1));
        end
      end
      REQ_COMP_ACQ: begin
        if (ready_cnt_q != '0) begin
          result.granted_id = ready_rdata;
          ready_head_d      = wrap_add(ready_head_q, CW'(1));
          ready_cnt_d       = CW'(ready_cnt_q - CW'(1));
        end else if (free_cnt_q != '0) begin
          result.granted_id = free_front;
          free_cnt_d        = CW'(free_cnt_q - CW'(1));
        end else begin
          result.status = ST_ERR;
        end
      end
      REQ_COMP_REL: begin
        if (!id_ok || free_cnt_q >= buf_cnt_q) begin
          result.status = ST_ERR;
        end else begin
          free_we    = 1'b1;
          free_cnt_d = CW'(free_cnt_q + CW'(1));
        end
      end
      REQ_SHUTDOWN: begin
        // only acts when the free deque has run dry
        if (free_cnt_q == '0) begin
          if (ready_cnt_q == '0) begin
            result.status = ST_ERR;
          end else begin
            free_we      = 1'b1;
            free_wdata   = ready_rdata;
            free_cnt_d   = CW'(free_cnt_q + CW'(1));
            ready_head_d = wrap_add(ready_head_q, CW'(1));
            ready_cnt_d  = CW'(ready_cnt_q - CW'(1));
          end
        end
      end
      default: result.status = ST_ERR;
    endcase
    if (!cmd_i.exec) begin
      free_we  = 1'b0;
      ready_we = 1'b0;
    end
  end

  // Queue state; a count write reinitializes everything
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_cnt_q    <= CW'(CntRst);
      free_head_q  <= '0;
      free_cnt_q   <= CW'(CntRst);
      ready_head_q <= '0;
      ready_cnt_q  <= '0;
      held_q       <= '0;
      free_vld_q   <= '0;
    end else if (cfg_we_i) begin
      buf_cnt_q    <= cfg_cnt;
      free_head_q  <= '0;
      free_cnt_q   <= cfg_cnt;
      ready_head_q <= '0;
      ready_cnt_q  <= '0;
      held_q       <= '0;
      free_vld_q   <= '0;
    end else if (cmd_i.exec) begin
      free_head_q  <= free_head_d;
      free_cnt_q   <= free_cnt_d;
      ready_head_q <= ready_head_d;
      ready_cnt_q  <= ready_cnt_d;
      held_q       <= held_d;
      if (free_we) free_vld_q[free_waddr] <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_q <= result;
    end
  end

  assign sts_o.out_blocked = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule
